[src/gn3d_pkg.sv]
// ----------------------------------------------------------------------------
// gn3d_pkg
// Shared types and constants for the gradient noise block.
// ----------------------------------------------------------------------------
package gn3d_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = 8;
    localparam int PERM_W     = 8;
    localparam int COORD_W    = 32;
    localparam int OUT_W      = 18;
    localparam int DIMS_W     = 2;
    localparam longint OUT_MAX = 131071;
    localparam longint OUT_MIN = -131072;

    typedef enum logic {
        OP_EVAL = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    localparam logic [DIMS_W-1:0] DIM_1   = 2'd1;
    localparam logic [DIMS_W-1:0] DIM_2   = 2'd2;
    localparam logic [DIMS_W-1:0] DIM_RST = 2'd3;

endpackage

[src/gradient_noise_1d_2d_3d_top.sv]
// ----------------------------------------------------------------------------
// gradient_noise_1d_2d_3d_top
// Improved gradient noise in one, two or three dimensions, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: op selects evaluate
//   or permutation load. A load writes table_index/table_value and gives no
//   result. An evaluate gives one noise_value on the output channel
//   (out_valid/out_ready). cfg_we/cfg_wdata set the dimension count; the user
//   must write it only while the block is idle; the block does not enforce
//   this. A value of 0 or 3 selects 3D. Throughput is one item per cycle unless
//   the output stalls. An evaluate takes three dependent permutation lookups
//   (one replicated RAM level per hash level), easing and three lerp levels.
//   The permutation sits in seven RAM copies; loads update each copy at the
//   stage that reads it, so lookups and loads stay in item order.
//   Reset clears the pipeline valids and sets 3D; the permutation is
//   undefined until loaded, and no clearing pass is run.
//   When the receiver stalls, the whole pipeline holds and in_ready drops
//   only while a finished result waits and out_ready is low.
// ----------------------------------------------------------------------------
module gradient_noise_1d_2d_3d_top
    import gn3d_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [IDX_W-1:0]         table_index,
    input  logic [PERM_W-1:0]        table_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  noise_value,
    input  logic                     cfg_we,
    input  logic [DIMS_W-1:0]        cfg_wdata
);

    localparam int FW = FRAC_BITS + 6;
    localparam int GW = FRAC_BITS + 4;
    localparam int DW = FRAC_BITS + 5;
    localparam longint RND = longint'(1) << (FRAC_BITS - 1);
    localparam logic signed [FW-1:0] C6     = FW'(6);
    localparam logic signed [FW-1:0] C15ONE = FW'(longint'(15) << FRAC_BITS);
    localparam logic signed [FW-1:0] C10ONE = FW'(longint'(10) << FRAC_BITS);
    localparam logic signed [GW-1:0] ONE_G  = GW'(longint'(1) << FRAC_BITS);

    function automatic logic signed [FW-1:0] qmul(
        input logic signed [FW-1:0] a,
        input logic signed [FW-1:0] b
    );
        logic signed [2*FW-1:0] p;
        p = a * b + (2*FW)'(RND);
        return FW'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [GW-1:0] lerp(
        input logic signed [FW-1:0] s,
        input logic signed [GW-1:0] a,
        input logic signed [GW-1:0] b
    );
        logic signed [DW-1:0]    d;
        logic signed [FW+DW-1:0] p;
        d = DW'(b) - DW'(a);
        p = (FW+DW)'(s) * (FW+DW)'(d) + (FW+DW)'(RND);
        return a + GW'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [GW-1:0] grad1(
        input logic [PERM_W-1:0]    h,
        input logic signed [GW-1:0] x
    );
        return h[0] ? -x : x;
    endfunction

    function automatic logic signed [GW-1:0] grad2(
        input logic [PERM_W-1:0]    h,
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] y
    );
        return (h[0] ? -x : x) + (h[1] ? -y : y);
    endfunction

    function automatic logic signed [GW-1:0] grad3(
        input logic [PERM_W-1:0]    hash,
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] y,
        input logic signed [GW-1:0] z
    );
        logic [3:0]           h;
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        h = hash[3:0];
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // ------------------------------------------------------------------ control
    logic              advance;
    logic              accept;
    logic [DIMS_W-1:0] dims_reg;
    logic              is_1d;
    logic              is_2d;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;
    assign is_1d    = (dims_reg == DIM_1);
    assign is_2d    = (dims_reg == DIM_2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIM_RST;
        end
        else if (cfg_we)
        begin
            dims_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------ stage regs
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                    s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic                    s1_op_reg, s2_op_reg, s3_op_reg;
    logic [IDX_W-1:0]        s1_celly_reg;
    logic [IDX_W-1:0]        s1_cellz_reg;
    logic [IDX_W-1:0]        s2_cellz_reg;
    logic [FRAC_BITS-1:0]    s1_frac_reg [3];
    logic [FRAC_BITS-1:0]    s2_frac_reg [3];
    logic [FRAC_BITS-1:0]    s3_frac_reg [3];
    logic [IDX_W-1:0]        s1_idx_reg, s2_idx_reg;
    logic [PERM_W-1:0]       s1_val_reg, s2_val_reg;
    logic [PERM_W-1:0]       s2_h1_reg [2];
    logic [PERM_W-1:0]       s3_h1_reg [2];
    logic [PERM_W-1:0]       s3_h2_reg [4];
    logic signed [FW-1:0]    s2_t2_reg [3];
    logic signed [FW-1:0]    s2_p1_reg [3];
    logic signed [FW-1:0]    s3_c_reg [3];
    logic signed [FW-1:0]    s3_poly_reg [3];
    logic signed [FW-1:0]    s4_fade_reg [3];
    logic signed [FW-1:0]    s5_fade_reg [3];
    logic signed [FW-1:0]    s6_fade_reg;
    logic signed [GW-1:0]    s4_g_reg [8];
    logic signed [GW-1:0]    s5_l_reg [4];
    logic signed [GW-1:0]    s6_n_reg [2];
    logic signed [GW-1:0]    s6_l0_reg;
    logic signed [OUT_W-1:0] noise_reg;

    // ------------------------------------------------------------------ memories
    logic [PERM_W-1:0] l1_rd [2];
    logic [PERM_W-1:0] l2_rd [2][2];
    logic [PERM_W-1:0] l3_rd [4][2];
    logic [IDX_W-1:0]  cx;
    logic [IDX_W-1:0]  l2_addr [2];
    logic [IDX_W-1:0]  l3_addr [4];
    logic              l2_we;
    logic              l3_we;

    assign cx    = coord_x[FRAC_BITS+IDX_W-1 -: IDX_W];
    assign l2_we = advance && s1_valid_reg && (s1_op_reg == OP_LOAD);
    assign l3_we = advance && s2_valid_reg && (s2_op_reg == OP_LOAD);

    gn3d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l1 (
        .clk     (clk),
        .we      (accept && (op == OP_LOAD)),
        .waddr   (table_index),
        .wdata   (table_value),
        .re      (advance),
        .raddr_a (cx),
        .raddr_b (cx + IDX_W'(1)),
        .rdata_a (l1_rd[0]),
        .rdata_b (l1_rd[1])
    );

    // Hash level two: A = perm(X) + Y, B = perm(X+1) + Y
    assign l2_addr[0] = l1_rd[0] + s1_celly_reg;
    assign l2_addr[1] = l1_rd[1] + s1_celly_reg;

    // Hash level three: AA, AB, BA, BB
    assign l3_addr[0] = l2_rd[0][0] + s2_cellz_reg;
    assign l3_addr[1] = l2_rd[0][1] + s2_cellz_reg;
    assign l3_addr[2] = l2_rd[1][0] + s2_cellz_reg;
    assign l3_addr[3] = l2_rd[1][1] + s2_cellz_reg;

    for (genvar gi = 0; gi < 2; gi++)
    begin : g_l2
        gn3d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l2 (
            .clk     (clk),
            .we      (l2_we),
            .waddr   (s1_idx_reg),
            .wdata   (s1_val_reg),
            .re      (advance),
            .raddr_a (l2_addr[gi]),
            .raddr_b (l2_addr[gi] + IDX_W'(1)),
            .rdata_a (l2_rd[gi][0]),
            .rdata_b (l2_rd[gi][1])
        );
    end

    for (genvar gi = 0; gi < 4; gi++)
    begin : g_l3
        gn3d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_ram_l3 (
            .clk     (clk),
            .we      (l3_we),
            .waddr   (s2_idx_reg),
            .wdata   (s2_val_reg),
            .re      (advance),
            .raddr_a (l3_addr[gi]),
            .raddr_b (l3_addr[gi] + IDX_W'(1)),
            .rdata_a (l3_rd[gi][0]),
            .rdata_b (l3_rd[gi][1])
        );
    end

    // ------------------------------------------------------------------ datapath
    logic signed [FW-1:0] s1_t2 [3];
    logic signed [FW-1:0] s1_p1 [3];
    logic signed [FW-1:0] s2_c [3];
    logic signed [FW-1:0] s2_poly [3];
    logic signed [FW-1:0] s3_fade [3];
    logic signed [GW-1:0] s3_g [8];
    logic signed [GW-1:0] s4_l [4];
    logic signed [GW-1:0] s5_n [2];
    logic signed [GW:0]   s6_res;
    logic signed [OUT_W-1:0] s6_sat;

    always_comb
    begin
        logic signed [FW-1:0] tq;
        for (int i = 0; i < 3; i++)
        begin
            tq       = FW'(s1_frac_reg[i]);
            s1_t2[i] = qmul(tq, tq);
            s1_p1[i] = qmul(tq, C6 * tq - C15ONE);
        end
    end

    always_comb
    begin
        logic signed [FW-1:0] tq;
        for (int i = 0; i < 3; i++)
        begin
            tq         = FW'(s2_frac_reg[i]);
            s2_c[i]    = qmul(s2_t2_reg[i], tq);
            s2_poly[i] = s2_p1_reg[i] + C10ONE;
        end
    end

    always_comb
    begin
        logic signed [GW-1:0] x0, y0, z0, x1, y1, z1;
        for (int i = 0; i < 3; i++)
        begin
            s3_fade[i] = qmul(s3_c_reg[i], s3_poly_reg[i]);
        end
        x0 = GW'(s3_frac_reg[0]);
        y0 = GW'(s3_frac_reg[1]);
        z0 = GW'(s3_frac_reg[2]);
        x1 = x0 - ONE_G;
        y1 = y0 - ONE_G;
        z1 = z0 - ONE_G;
        for (int i = 0; i < 8; i++)
        begin
            s3_g[i] = '0;
        end
        if (is_1d)
        begin
            s3_g[0] = grad1(s3_h1_reg[0], x0);
            s3_g[1] = grad1(s3_h1_reg[1], x1);
        end
        else if (is_2d)
        begin
            s3_g[0] = grad2(s3_h2_reg[0], x0, y0);
            s3_g[1] = grad2(s3_h2_reg[2], x1, y0);
            s3_g[2] = grad2(s3_h2_reg[1], x0, y1);
            s3_g[3] = grad2(s3_h2_reg[3], x1, y1);
        end
        else
        begin
            // copies: 0 = AA, 1 = AB, 2 = BA, 3 = BB; port b holds the +1 entry
            s3_g[0] = grad3(l3_rd[0][0], x0, y0, z0);
            s3_g[1] = grad3(l3_rd[2][0], x1, y0, z0);
            s3_g[2] = grad3(l3_rd[1][0], x0, y1, z0);
            s3_g[3] = grad3(l3_rd[3][0], x1, y1, z0);
            s3_g[4] = grad3(l3_rd[0][1], x0, y0, z1);
            s3_g[5] = grad3(l3_rd[2][1], x1, y0, z1);
            s3_g[6] = grad3(l3_rd[1][1], x0, y1, z1);
            s3_g[7] = grad3(l3_rd[3][1], x1, y1, z1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s4_l[i] = lerp(s4_fade_reg[0], s4_g_reg[2*i], s4_g_reg[2*i+1]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s5_n[i] = lerp(s5_fade_reg[1], s5_l_reg[2*i], s5_l_reg[2*i+1]);
        end
    end

    always_comb
    begin
        longint r;
        if (is_1d)
        begin
            s6_res = (GW+1)'(s6_l0_reg) <<< 1;
        end
        else if (is_2d)
        begin
            s6_res = (GW+1)'(s6_n_reg[0]);
        end
        else
        begin
            s6_res = (GW+1)'(lerp(s6_fade_reg, s6_n_reg[0], s6_n_reg[1]));
        end
        r = longint'(s6_res);
        if (r > OUT_MAX)
        begin
            s6_sat = OUT_W'(OUT_MAX);
        end
        else if (r < OUT_MIN)
        begin
            s6_sat = OUT_W'(OUT_MIN);
        end
        else
        begin
            s6_sat = OUT_W'(r);
        end
    end

    // ------------------------------------------------------------------ valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            // drop load items once their last table copy is written
            s4_valid_reg <= s3_valid_reg && (s3_op_reg == OP_EVAL);
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            out_valid    <= s6_valid_reg;
        end
    end

    // ------------------------------------------------------------------ payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg      <= op;
            s1_celly_reg   <= coord_y[FRAC_BITS+IDX_W-1 -: IDX_W];
            s1_cellz_reg   <= coord_z[FRAC_BITS+IDX_W-1 -: IDX_W];
            s1_frac_reg[0] <= coord_x[FRAC_BITS-1:0];
            s1_frac_reg[1] <= coord_y[FRAC_BITS-1:0];
            s1_frac_reg[2] <= coord_z[FRAC_BITS-1:0];
            s1_idx_reg     <= table_index;
            s1_val_reg     <= table_value;

            s2_op_reg    <= s1_op_reg;
            s2_cellz_reg <= s1_cellz_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_val_reg   <= s1_val_reg;
            s2_h1_reg[0] <= l1_rd[0];
            s2_h1_reg[1] <= l1_rd[1];

            s3_op_reg    <= s2_op_reg;
            s3_h1_reg[0] <= s2_h1_reg[0];
            s3_h1_reg[1] <= s2_h1_reg[1];
            s3_h2_reg[0] <= l2_rd[0][0];
            s3_h2_reg[1] <= l2_rd[0][1];
            s3_h2_reg[2] <= l2_rd[1][0];
            s3_h2_reg[3] <= l2_rd[1][1];

            for (int i = 0; i < 3; i++)
            begin
                s2_frac_reg[i] <= s1_frac_reg[i];
                s2_t2_reg[i]   <= s1_t2[i];
                s2_p1_reg[i]   <= s1_p1[i];
                s3_frac_reg[i] <= s2_frac_reg[i];
                s3_c_reg[i]    <= s2_c[i];
                s3_poly_reg[i] <= s2_poly[i];
                s4_fade_reg[i] <= s3_fade[i];
                s5_fade_reg[i] <= s4_fade_reg[i];
            end
            for (int i = 0; i < 8; i++)
            begin
                s4_g_reg[i] <= s3_g[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                s5_l_reg[i] <= s4_l[i];
            end
            s6_n_reg[0] <= s5_n[0];
            s6_n_reg[1] <= s5_n[1];
            s6_l0_reg   <= s5_l_reg[0];
            s6_fade_reg <= s5_fade_reg[2];
            noise_reg   <= s6_sat;
        end
    end

    assign noise_value = noise_reg;

endmodule

[src/gn3d_ram.sv]
// ----------------------------------------------------------------------------
// gn3d_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module gn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
